>>> sv/sev4j_pkg.sv
// ----------------------------------------------------------------------------
// Smallest eigenvector unit package
// Item types, register indexes and reset values for the 4x4 Jacobi unit.
// ----------------------------------------------------------------------------
package sev4j_pkg;

    // Inner fixed-point format: signed, INNER_W bits, FRAC_W fractional bits.
    localparam int INNER_W = 48;
    localparam int FRAC_W  = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SWEEP_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_CONVERGE_LEVEL = 2'd1;
    localparam logic [1:0] CFG_SKIP_LEVEL     = 2'd2;

    // Register reset values.
    localparam logic [5:0]         RST_SWEEP_LIMIT    = 6'd50;
    localparam logic [INNER_W-1:0] RST_CONVERGE_LEVEL = '0;
    localparam logic [INNER_W-1:0] RST_SKIP_LEVEL     = '0;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
        logic signed [31:0] m33;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] vec0;
        logic signed [31:0] vec1;
        logic signed [31:0] vec2;
        logic signed [31:0] vec3;
    } t_out_item;

endpackage

>>> sv/smallest_eigvec_sym4_jacobi_unit.sv
// ----------------------------------------------------------------------------
// Smallest eigenvector of a symmetric 4x4 matrix
// Cyclic Jacobi rotations on a shared multiplier and shift-subtract unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item runs sweeps over the six index pairs, skipping a pair whose
// off-diagonal magnitude is at most the skip level. The 24x24 multiplier and
// the one-bit-per-cycle root and divide unit do the arithmetic. o_in_stall
// is high from the transfer in until the result is moved to the output
// register, which holds it while i_out_stall is high. Reset (synchronous,
// active low) returns the sequencer to idle, drops any pending result and
// restores the register defaults.
// ----------------------------------------------------------------------------
module smallest_eigvec_sym4_jacobi_unit
    import sev4j_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [INNER_W-1:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOAD  = 5'd1;
    localparam logic [4:0] S_SWP   = 5'd2;
    localparam logic [4:0] S_ORD   = 5'd3;
    localparam logic [4:0] S_OMUL  = 5'd4;
    localparam logic [4:0] S_OWAIT = 5'd5;
    localparam logic [4:0] S_OCMP  = 5'd6;
    localparam logic [4:0] S_RRD0  = 5'd7;
    localparam logic [4:0] S_RRD1  = 5'd8;
    localparam logic [4:0] S_RRD2  = 5'd9;
    localparam logic [4:0] S_REE   = 5'd10;
    localparam logic [4:0] S_RGG   = 5'd11;
    localparam logic [4:0] S_RSQ1  = 5'd12;
    localparam logic [4:0] S_RDV1  = 5'd13;
    localparam logic [4:0] S_RTT   = 5'd14;
    localparam logic [4:0] S_RSQ2  = 5'd15;
    localparam logic [4:0] S_RDV2  = 5'd16;
    localparam logic [4:0] S_RTS   = 5'd17;
    localparam logic [4:0] S_ERD   = 5'd18;
    localparam logic [4:0] S_EMUL  = 5'd19;
    localparam logic [4:0] S_EWAIT = 5'd20;
    localparam logic [4:0] S_EWP   = 5'd21;
    localparam logic [4:0] S_EWQ   = 5'd22;
    localparam logic [4:0] S_NEXT  = 5'd23;
    localparam logic [4:0] S_PRD   = 5'd24;
    localparam logic [4:0] S_PCMP  = 5'd25;
    localparam logic [4:0] S_VRD   = 5'd26;
    localparam logic [4:0] S_VST   = 5'd27;
    localparam logic [4:0] S_DONE  = 5'd28;

    localparam logic [6:0] DIV_STEPS  = 7'd80;
    localparam logic [6:0] SQRT_STEPS = 7'd48;

    // ---------------------------------------------------------------- helpers
    function automatic logic [47:0] mag48(logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic logic signed [47:0] sat49(logic signed [48:0] s);
        logic signed [47:0] res;
        if (s[48] != s[47]) begin
            res = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
            res = s[47:0];
        end
        return res;
    endfunction

    function automatic logic signed [47:0] fix_out(logic [95:0] acc, logic neg);
        logic [63:0] pm;
        logic [63:0] lim;
        pm  = acc[95:32];
        lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        if (pm > lim) begin
            pm = lim;
        end
        return neg ? 48'(-pm[47:0]) : pm[47:0];
    endfunction

    function automatic logic [31:0] to_out(logic signed [47:0] v);
        logic [47:0] m;
        logic [46:0] m2;
        m  = mag48(v);
        m2 = {1'b0, m[47:2]} + {46'b0, m[1]};
        if (m2 > 47'h4000_0000) begin
            m2 = 47'h4000_0000;
        end
        return v[47] ? 32'(-m2[31:0]) : m2[31:0];
    endfunction

    function automatic logic signed [31:0] in_entry(t_in_item it, logic [1:0] rw,
                                                    logic [1:0] cl);
        logic [1:0] lo;
        logic [1:0] hi;
        logic signed [31:0] res;
        lo = (rw < cl) ? rw : cl;
        hi = (rw < cl) ? cl : rw;
        case ({lo, hi})
            4'b0000: res = it.m00;
            4'b0001: res = it.m01;
            4'b0010: res = it.m02;
            4'b0011: res = it.m03;
            4'b0101: res = it.m11;
            4'b0110: res = it.m12;
            4'b0111: res = it.m13;
            4'b1010: res = it.m22;
            4'b1011: res = it.m23;
            default: res = it.m33;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] pair_p(logic [2:0] idx);
        logic [1:0] res;
        case (idx)
            3'd0, 3'd1, 3'd2: res = 2'd0;
            3'd3, 3'd4:       res = 2'd1;
            default:          res = 2'd2;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] pair_q(logic [2:0] idx);
        logic [1:0] res;
        case (idx)
            3'd0:       res = 2'd1;
            3'd1, 3'd3: res = 2'd2;
            default:    res = 2'd3;
        endcase
        return res;
    endfunction

    // -------------------------------------------------------------- registers
    logic [4:0]   r_state, n_state;
    t_in_item     r_in, n_in;
    logic [4:0]   r_cnt, n_cnt;
    logic [2:0]   r_pair, n_pair;
    logic [5:0]   r_sweep, n_sweep;
    logic [1:0]   r_sub, n_sub;
    logic [96:0]  r_off, n_off;
    logic [97:0]  r_rad, n_rad;
    logic [47:0]  r_g, n_g;
    logic         r_aneg, n_aneg;
    logic signed [47:0] r_mpp, n_mpp;
    logic [47:0]  r_e, n_e;
    logic         r_negt, n_negt;
    logic [32:0]  r_tm, n_tm;
    logic [32:0]  r_cm, n_cm;
    logic [32:0]  r_sm, n_sm;
    logic signed [47:0] r_prod [4];
    logic signed [47:0] n_prod [4];
    logic [1:0]   r_best, n_best;
    logic signed [47:0] r_bval, n_bval;
    t_out_item    r_vec, n_vec;
    t_out_item    r_out, n_out;
    logic         r_ovalid, n_ovalid;
    logic [5:0]   r_sweep_limit, n_sweep_limit;
    logic [47:0]  r_converge, n_converge;
    logic [47:0]  r_skip, n_skip;

    // Multiplier: four 24x24 partial products, one per cycle, registered.
    logic         r_mbusy, n_mbusy;
    logic [2:0]   r_mcnt, n_mcnt;
    logic [47:0]  r_ma, n_ma;
    logic [47:0]  r_mb, n_mb;
    logic         r_mneg, n_mneg;
    logic [95:0]  r_pp, n_pp;
    logic [95:0]  r_acc, n_acc;

    // Shift-subtract unit: one root digit or one quotient bit per cycle.
    logic         r_sbusy, n_sbusy;
    logic [6:0]   r_scnt, n_scnt;
    logic         r_sdiv, n_sdiv;
    logic [97:0]  r_src, n_src;
    logic [49:0]  r_d, n_d;
    logic [52:0]  r_rem, n_rem;
    logic [48:0]  r_res, n_res;

    // Matrix (rows 0..15) and vector matrix (16..31).
    logic [47:0]  r_mem [32];
    logic signed [47:0] r_rda;
    logic signed [47:0] r_rdb;
    logic         mem_we;
    logic [4:0]   mem_waddr;
    logic [47:0]  mem_wdata;
    logic         mem_re;
    logic [4:0]   mem_ra;
    logic [4:0]   mem_rb;

    // ----------------------------------------------------------- datapath
    logic [1:0]   el_p, el_q, el_k;
    logic [4:0]   el_xa, el_ya;
    logic [23:0]  m_ah, m_bh;
    logic [47:0]  m_pp48;
    logic [52:0]  s_rem_sh, s_trial;
    logic         s_ge;
    logic [48:0]  e_diff;
    logic [49:0]  r_den;
    logic signed [31:0] ld_val;

    always_comb begin
        el_p = pair_p(r_pair);
        el_q = pair_q(r_pair);
        el_k = r_cnt[1:0];
        case (r_cnt[3:2])
            2'd0: begin
                el_xa = {1'b0, el_k, el_p};
                el_ya = {1'b0, el_k, el_q};
            end
            2'd1: begin
                el_xa = {1'b0, el_p, el_k};
                el_ya = {1'b0, el_q, el_k};
            end
            default: begin
                el_xa = {1'b1, el_k, el_p};
                el_ya = {1'b1, el_k, el_q};
            end
        endcase
    end

    assign m_ah   = r_mcnt[0] ? r_ma[47:24] : r_ma[23:0];
    assign m_bh   = r_mcnt[1] ? r_mb[47:24] : r_mb[23:0];
    assign m_pp48 = m_ah * m_bh;

    assign s_rem_sh = r_sdiv ? {r_rem[51:0], r_src[97]} : {r_rem[50:0], r_src[97:96]};
    assign s_trial  = r_sdiv ? {3'b0, r_d} : {2'b0, r_res, 2'b01};
    assign s_ge     = (s_rem_sh >= s_trial);

    assign e_diff = {r_rda[47], r_rda} - {r_mpp[47], r_mpp};
    assign r_den  = {2'b0, r_e} + {1'b0, r_res};
    assign ld_val = in_entry(r_in, r_cnt[3:2], r_cnt[1:0]);

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;   n_in = r_in;       n_cnt = r_cnt;     n_pair = r_pair;
        n_sweep = r_sweep;   n_sub = r_sub;     n_off = r_off;     n_rad = r_rad;
        n_g = r_g;           n_aneg = r_aneg;   n_mpp = r_mpp;     n_e = r_e;
        n_negt = r_negt;     n_tm = r_tm;       n_cm = r_cm;       n_sm = r_sm;
        n_prod = r_prod;     n_best = r_best;   n_bval = r_bval;   n_vec = r_vec;
        n_out = r_out;
        n_sweep_limit = r_sweep_limit;
        n_converge = r_converge;
        n_skip = r_skip;
        n_mbusy = r_mbusy;   n_mcnt = r_mcnt;   n_ma = r_ma;       n_mb = r_mb;
        n_mneg = r_mneg;     n_pp = r_pp;       n_acc = r_acc;
        n_sbusy = r_sbusy;   n_scnt = r_scnt;   n_sdiv = r_sdiv;   n_src = r_src;
        n_d = r_d;           n_rem = r_rem;     n_res = r_res;
        mem_we = 1'b0;  mem_waddr = el_xa;  mem_wdata = '0;
        mem_re = 1'b0;  mem_ra = el_xa;     mem_rb = el_ya;

        // A result leaves the output register on its transfer.
        n_ovalid = r_ovalid & i_out_stall;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SWEEP_LIMIT:    n_sweep_limit = i_cfg_data[5:0];
                CFG_CONVERGE_LEVEL: n_converge    = i_cfg_data;
                CFG_SKIP_LEVEL:     n_skip        = i_cfg_data;
                default: ;
            endcase
        end

        if (r_mbusy) begin
            n_pp = 96'({48'b0, m_pp48}) << (6'd24 * ({5'b0, r_mcnt[0]} + {5'b0, r_mcnt[1]}));
            if (r_mcnt != 3'd0) begin
                n_acc = r_acc + r_pp;
            end
            n_mcnt = r_mcnt + 3'd1;
            if (r_mcnt == 3'd4) begin
                n_mbusy = 1'b0;
            end
        end

        if (r_sbusy) begin
            n_rem = s_ge ? (s_rem_sh - s_trial) : s_rem_sh;
            n_res = {r_res[47:0], s_ge};
            n_src = r_sdiv ? {r_src[96:0], 1'b0} : {r_src[95:0], 2'b0};
            n_scnt = r_scnt - 7'd1;
            if (r_scnt == 7'd0) begin
                n_sbusy = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_data;
                    n_cnt = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                mem_we = 1'b1;
                mem_waddr = r_cnt;
                if (!r_cnt[4]) begin
                    mem_wdata = {ld_val, 16'b0};
                end else if (r_cnt[3:2] == r_cnt[1:0]) begin
                    mem_wdata = 48'h0001_0000_0000;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_sweep = '0;
                    n_state = S_SWP;
                end
            end
            S_SWP: begin
                n_cnt = '0;
                if (r_sweep < r_sweep_limit) begin
                    n_off = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_ORD: begin
                mem_re = 1'b1;
                mem_ra = {1'b0, pair_p(r_cnt[2:0]), pair_q(r_cnt[2:0])};
                n_state = S_OMUL;
            end
            S_OMUL: begin
                n_mbusy = 1'b1;  n_mcnt = '0;  n_acc = '0;  n_mneg = 1'b0;
                n_ma = mag48(r_rda);
                n_mb = mag48(r_rda);
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                if (!r_mbusy) begin
                    n_off = r_off + {1'b0, r_acc};
                    if (r_cnt == 5'd5) begin
                        n_state = S_OCMP;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                        n_state = S_ORD;
                    end
                end
            end
            S_OCMP: begin
                n_cnt = '0;
                n_pair = '0;
                n_state = (r_off < {49'b0, r_converge}) ? S_PRD : S_RRD0;
            end
            S_RRD0: begin
                mem_re = 1'b1;
                mem_ra = {1'b0, el_p, el_q};
                mem_rb = {1'b0, el_p, el_p};
                n_state = S_RRD1;
            end
            S_RRD1: begin
                mem_re = 1'b1;
                mem_ra = {1'b0, el_q, el_q};
                n_g = mag48(r_rda);
                n_aneg = r_rda[47];
                n_mpp = r_rdb;
                n_state = (mag48(r_rda) <= r_skip) ? S_NEXT : S_RRD2;
            end
            S_RRD2: begin
                // The halving guard of the rotation never fires at 48 bits.
                n_e = e_diff[48] ? 48'(-e_diff) : e_diff[47:0];
                n_negt = (r_rda != r_mpp) && ((r_rda < r_mpp) != r_aneg);
                n_mbusy = 1'b1;  n_mcnt = '0;  n_acc = '0;  n_mneg = 1'b0;
                n_ma = e_diff[48] ? 48'(-e_diff) : e_diff[47:0];
                n_mb = e_diff[48] ? 48'(-e_diff) : e_diff[47:0];
                n_state = S_REE;
            end
            S_REE: begin
                if (!r_mbusy) begin
                    n_rad = {2'b0, r_acc};
                    n_mbusy = 1'b1;  n_mcnt = '0;  n_acc = '0;
                    n_ma = r_g;
                    n_mb = r_g;
                    n_state = S_RGG;
                end
            end
            S_RGG: begin
                if (!r_mbusy) begin
                    n_sbusy = 1'b1;  n_sdiv = 1'b0;  n_scnt = SQRT_STEPS;
                    n_rem = '0;  n_res = '0;  n_d = '0;
                    n_src = r_rad + {r_acc, 2'b0};
                    n_state = S_RSQ1;
                end
            end
            S_RSQ1: begin
                if (!r_sbusy) begin
                    if (r_den == '0) begin
                        n_state = S_NEXT;
                    end else begin
                        n_sbusy = 1'b1;  n_sdiv = 1'b1;  n_scnt = DIV_STEPS;
                        n_rem = '0;  n_res = '0;
                        n_d = r_den;
                        n_src = {r_g, 50'b0};
                        n_state = S_RDV1;
                    end
                end
            end
            S_RDV1: begin
                if (!r_sbusy) begin
                    n_tm = r_res[32:0];
                    n_mbusy = 1'b1;  n_mcnt = '0;  n_acc = '0;
                    n_ma = {15'b0, r_res[32:0]};
                    n_mb = {15'b0, r_res[32:0]};
                    n_state = S_RTT;
                end
            end
            S_RTT: begin
                if (!r_mbusy) begin
                    n_sbusy = 1'b1;  n_sdiv = 1'b0;  n_scnt = SQRT_STEPS;
                    n_rem = '0;  n_res = '0;
                    n_src = {2'b0, r_acc} + (98'd1 << 64);
                    n_state = S_RSQ2;
                end
            end
            S_RSQ2: begin
                if (!r_sbusy) begin
                    n_sbusy = 1'b1;  n_sdiv = 1'b1;  n_scnt = DIV_STEPS;
                    n_rem = '0;  n_res = '0;
                    n_d = {17'b0, r_res[32:0]};
                    n_src = 98'd1 << 81;
                    n_state = S_RDV2;
                end
            end
            S_RDV2: begin
                if (!r_sbusy) begin
                    n_cm = r_res[32:0];
                    n_mbusy = 1'b1;  n_mcnt = '0;
                    n_acc = 96'd1 << (FRAC_W - 1);
                    n_ma = {15'b0, r_tm};
                    n_mb = {15'b0, r_res[32:0]};
                    n_state = S_RTS;
                end
            end
            S_RTS: begin
                if (!r_mbusy) begin
                    n_sm = r_acc[64:32];
                    n_cnt = '0;
                    n_sub = '0;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                mem_re = 1'b1;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                n_mbusy = 1'b1;  n_mcnt = '0;
                n_acc = 96'd1 << (FRAC_W - 1);
                case (r_sub)
                    2'd0: begin
                        n_ma = {15'b0, r_cm};  n_mb = mag48(r_rda);  n_mneg = r_rda[47];
                    end
                    2'd1: begin
                        n_ma = {15'b0, r_sm};  n_mb = mag48(r_rdb);
                        n_mneg = r_negt ^ r_rdb[47];
                    end
                    2'd2: begin
                        n_ma = {15'b0, r_sm};  n_mb = mag48(r_rda);
                        n_mneg = r_negt ^ r_rda[47];
                    end
                    default: begin
                        n_ma = {15'b0, r_cm};  n_mb = mag48(r_rdb);  n_mneg = r_rdb[47];
                    end
                endcase
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                if (!r_mbusy) begin
                    n_prod[r_sub] = fix_out(r_acc, r_mneg);
                    n_sub = r_sub + 2'd1;
                    n_state = (r_sub == 2'd3) ? S_EWP : S_EMUL;
                end
            end
            S_EWP: begin
                mem_we = 1'b1;
                mem_waddr = el_xa;
                mem_wdata = sat49({r_prod[0][47], r_prod[0]} - {r_prod[1][47], r_prod[1]});
                n_state = S_EWQ;
            end
            S_EWQ: begin
                mem_we = 1'b1;
                mem_waddr = el_ya;
                mem_wdata = sat49({r_prod[2][47], r_prod[2]} + {r_prod[3][47], r_prod[3]});
                if (r_cnt == 5'd11) begin
                    n_state = S_NEXT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                    n_state = S_ERD;
                end
            end
            S_NEXT: begin
                if (r_pair == 3'd5) begin
                    n_pair = '0;
                    n_sweep = r_sweep + 6'd1;
                    n_state = S_SWP;
                end else begin
                    n_pair = r_pair + 3'd1;
                    n_state = S_RRD0;
                end
            end
            S_PRD: begin
                mem_re = 1'b1;
                mem_ra = {1'b0, r_cnt[1:0], r_cnt[1:0]};
                n_state = S_PCMP;
            end
            S_PCMP: begin
                // Strictly smaller only, so the first smallest diagonal wins.
                if (r_cnt[1:0] == 2'd0 || r_rda < r_bval) begin
                    n_best = r_cnt[1:0];
                    n_bval = r_rda;
                end
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt = '0;
                    n_state = S_VRD;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                    n_state = S_PRD;
                end
            end
            S_VRD: begin
                mem_re = 1'b1;
                mem_ra = {1'b1, r_cnt[1:0], r_best};
                n_state = S_VST;
            end
            S_VST: begin
                case (r_cnt[1:0])
                    2'd0:    n_vec.vec0 = to_out(r_rda);
                    2'd1:    n_vec.vec1 = to_out(r_rda);
                    2'd2:    n_vec.vec2 = to_out(r_rda);
                    default: n_vec.vec3 = to_out(r_rda);
                endcase
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                    n_state = S_VRD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out = r_vec;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mbusy       <= 1'b0;
            r_sbusy       <= 1'b0;
            r_ovalid      <= 1'b0;
            r_sweep_limit <= RST_SWEEP_LIMIT;
            r_converge    <= RST_CONVERGE_LEVEL;
            r_skip        <= RST_SKIP_LEVEL;
        end else begin
            r_state       <= n_state;
            r_mbusy       <= n_mbusy;
            r_sbusy       <= n_sbusy;
            r_ovalid      <= n_ovalid;
            r_sweep_limit <= n_sweep_limit;
            r_converge    <= n_converge;
            r_skip        <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;     r_cnt <= n_cnt;     r_pair <= n_pair;   r_sweep <= n_sweep;
        r_sub <= n_sub;   r_off <= n_off;     r_rad <= n_rad;     r_g <= n_g;
        r_aneg <= n_aneg; r_mpp <= n_mpp;     r_e <= n_e;         r_negt <= n_negt;
        r_tm <= n_tm;     r_cm <= n_cm;       r_sm <= n_sm;       r_prod <= n_prod;
        r_best <= n_best; r_bval <= n_bval;   r_vec <= n_vec;     r_out <= n_out;
        r_mcnt <= n_mcnt; r_ma <= n_ma;       r_mb <= n_mb;       r_mneg <= n_mneg;
        r_pp <= n_pp;     r_acc <= n_acc;
        r_scnt <= n_scnt; r_sdiv <= n_sdiv;   r_src <= n_src;     r_d <= n_d;
        r_rem <= n_rem;   r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rda <= r_mem[mem_ra];
            r_rdb <= r_mem[mem_rb];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mbusy && r_sbusy))
        else $error("multiplier and shift-subtract unit busy together");

    a_stall_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer in");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !mem_we)
        else $error("matrix store written outside an item");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair <= 3'd5)
        else $error("pair index out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ovalid ##1 r_ovalid) |-> $past(r_state) == S_DONE)
        else $error("result appeared without finishing an item");
`endif

endmodule
